[design/rrac_pkg.sv]
// Shared types, register codes and constants of the rounded-rectangle coverage core.
`timescale 1ns / 1ps

package rrac_pkg;

  // Band half-width of the outline in Q.8 (1.45 pixel).
  localparam int unsigned BAND_Q8 = 371;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_RADIUS  = 3'd2,
    REG_FILL    = 3'd3,
    REG_SAMPLES = 3'd4,
    REG_FG      = 3'd5,
    REG_BG      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [11:0] corner_radius;
    logic        fill_mode;
    logic [3:0]  samples_per_axis;
    logic [31:0] fg_color;
    logic [23:0] bg_color;
  } cfg_t;

  // Sample offsets in Q.8: row is samples per axis minus one, column the sample index.
  localparam logic [7:0] OFF_TAB [8][8] = '{
    '{8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd64,  8'd192, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd43,  8'd128, 8'd213, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd32,  8'd96,  8'd160, 8'd224, 8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd26,  8'd77,  8'd128, 8'd179, 8'd230, 8'd0,   8'd0,   8'd0  },
    '{8'd21,  8'd64,  8'd107, 8'd149, 8'd192, 8'd235, 8'd0,   8'd0  },
    '{8'd18,  8'd55,  8'd91,  8'd128, 8'd165, 8'd201, 8'd238, 8'd0  },
    '{8'd16,  8'd48,  8'd80,  8'd112, 8'd144, 8'd176, 8'd208, 8'd240}
  };

endpackage

[design/rrac_regs.sv]
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module rrac_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rrac_pkg::cfg_t      cfg_o
);

  rrac_pkg::cfg_t cfg_q;
  logic [2:0]     idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect_width       <= 13'd64;
      cfg_q.rect_height      <= 13'd64;
      cfg_q.corner_radius    <= 12'd8;
      cfg_q.fill_mode        <= 1'b1;
      cfg_q.samples_per_axis <= 4'd4;
      cfg_q.fg_color         <= 32'hFFFF_FFFF;
      cfg_q.bg_color         <= 24'h00_0000;
    end else if (psel && penable && pwrite) begin
      case (idx)
        rrac_pkg::REG_WIDTH:   cfg_q.rect_width       <= pwdata[12:0];
        rrac_pkg::REG_HEIGHT:  cfg_q.rect_height      <= pwdata[12:0];
        rrac_pkg::REG_RADIUS:  cfg_q.corner_radius    <= pwdata[11:0];
        rrac_pkg::REG_FILL:    cfg_q.fill_mode        <= pwdata[0];
        rrac_pkg::REG_SAMPLES: cfg_q.samples_per_axis <= pwdata[3:0];
        rrac_pkg::REG_FG:      cfg_q.fg_color         <= pwdata;
        rrac_pkg::REG_BG:      cfg_q.bg_color         <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rrac_pkg::REG_WIDTH:   prdata = {19'd0, cfg_q.rect_width};
      rrac_pkg::REG_HEIGHT:  prdata = {19'd0, cfg_q.rect_height};
      rrac_pkg::REG_RADIUS:  prdata = {20'd0, cfg_q.corner_radius};
      rrac_pkg::REG_FILL:    prdata = {31'd0, cfg_q.fill_mode};
      rrac_pkg::REG_SAMPLES: prdata = {28'd0, cfg_q.samples_per_axis};
      rrac_pkg::REG_FG:      prdata = cfg_q.fg_color;
      rrac_pkg::REG_BG:      prdata = {8'd0, cfg_q.bg_color};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

[design/rrac_geom.sv]
// Sample geometry pipeline: five stages from pixel coordinate to per-sample hit mask.
`timescale 1ns / 1ps

module rrac_geom #(
  parameter int MAX_DIM     = 4096,
  parameter int MAX_SAMPLES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  rrac_pkg::pix_in_t                pix_i,
  input  rrac_pkg::cfg_t                   cfg_i,
  output logic                             valid_o,
  output logic [MAX_SAMPLES*MAX_SAMPLES-1:0] hits_o
);

  localparam int NS = MAX_SAMPLES;

  // stage 1 comb
  logic [12:0] w_s, h_s, mins;
  logic [19:0] lim, r8_raw, r8_c;
  logic [3:0]  s_c;

  always_comb begin
    w_s    = (int'(cfg_i.rect_width) > MAX_DIM) ? 13'(MAX_DIM) : cfg_i.rect_width;
    h_s    = (int'(cfg_i.rect_height) > MAX_DIM) ? 13'(MAX_DIM) : cfg_i.rect_height;
    mins   = (w_s < h_s) ? w_s : h_s;
    lim    = {mins - 13'd1, 7'd0};
    r8_raw = {cfg_i.corner_radius, 8'd0};
    r8_c   = (r8_raw > lim) ? lim : r8_raw;
    if (cfg_i.samples_per_axis == 4'd0) begin
      s_c = 4'd1;
    end else if (int'(cfg_i.samples_per_axis) > NS) begin
      s_c = 4'(NS);
    end else begin
      s_c = cfg_i.samples_per_axis;
    end
  end

  logic [4:0]  v_q;
  logic [11:0] px1_q, py1_q;
  logic [3:0]  s_q   [1:4];
  logic        fill_q[1:4];
  logic        zero_q[1:4];
  logic [19:0] r8_q  [1:4];
  logic [19:0] cx1_q, cy1_q;

  // stage 2 values
  logic [20:0] ax2_q [NS], ay2_q [NS];
  logic [19:0] hx2_q, hy2_q;
  logic [39:0] r2_q  [2:4];
  logic [41:0] hi2_q [2:4];
  logic [39:0] lo2_q [2:4];

  // stage 3 / 4 values
  logic signed [21:0] qx3_q [NS], qy3_q [NS];
  logic signed [21:0] qx4_q [NS], qy4_q [NS];
  logic [41:0]        ox2_q [NS], oy2_q [NS];

  logic [NS*NS-1:0] hits_q;

  logic [2:0]  srow;
  logic [20:0] hi_c, lo_c;
  logic [20:0] ax_d [NS], ay_d [NS];
  logic signed [21:0] qx_d [NS], qy_d [NS];
  logic [41:0] ox2_d [NS], oy2_d [NS];
  logic [NS*NS-1:0] hits_d;

  always_comb begin
    logic [20:0] posx, posy;
    logic signed [22:0] dx, dy;
    srow = 3'(s_q[1] - 4'd1);
    for (int k = 0; k < NS; k++) begin
      posx = 21'({px1_q, 8'd0}) + 21'(rrac_pkg::OFF_TAB[srow][k]);
      posy = 21'({py1_q, 8'd0}) + 21'(rrac_pkg::OFF_TAB[srow][k]);
      dx = $signed({2'b00, posx}) - $signed({3'b000, cx1_q});
      dy = $signed({2'b00, posy}) - $signed({3'b000, cy1_q});
      ax_d[k] = dx[22] ? 21'(-dx) : dx[20:0];
      ay_d[k] = dy[22] ? 21'(-dy) : dy[20:0];
    end
  end

  always_comb begin
    hi_c = 21'(r8_q[1]) + 21'(rrac_pkg::BAND_Q8);
    lo_c = 21'(r8_q[1]) - 21'(rrac_pkg::BAND_Q8);
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      qx_d[k] = $signed({1'b0, ax2_q[k]}) - $signed({2'b00, hx2_q});
      qy_d[k] = $signed({1'b0, ay2_q[k]}) - $signed({2'b00, hy2_q});
    end
  end

  always_comb begin
    logic [20:0] ox, oy;
    for (int k = 0; k < NS; k++) begin
      ox = (qx3_q[k] > 0) ? qx3_q[k][20:0] : 21'd0;
      oy = (qy3_q[k] > 0) ? qy3_q[k][20:0] : 21'd0;
      ox2_d[k] = 42'(ox * ox);
      oy2_d[k] = 42'(oy * oy);
    end
  end

  always_comb begin
    logic [42:0]        h2;
    logic signed [21:0] m;
    logic signed [22:0] gap;
    logic               hit;
    for (int ky = 0; ky < NS; ky++) begin
      for (int kx = 0; kx < NS; kx++) begin
        h2  = 43'(ox2_q[kx]) + 43'(oy2_q[ky]);
        m   = (qx4_q[kx] > qy4_q[ky]) ? qx4_q[kx] : qy4_q[ky];
        gap = $signed({3'b000, r8_q[4]}) - 23'(m);
        if (fill_q[4]) begin
          hit = (h2 <= 43'(r2_q[4]));
        end else if (qx4_q[kx] <= 0 && qy4_q[ky] <= 0) begin
          hit = (gap <= $signed(23'(rrac_pkg::BAND_Q8)));
        end else begin
          hit = (h2 <= 43'(hi2_q[4])) && !(h2 < 43'(lo2_q[4]));
        end
        hits_d[ky*NS+kx] = hit && !zero_q[4] &&
                           (kx < int'(s_q[4])) && (ky < int'(s_q[4]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      px1_q     <= pix_i.pixel_x;
      py1_q     <= pix_i.pixel_y;
      s_q[1]    <= s_c;
      fill_q[1] <= cfg_i.fill_mode;
      zero_q[1] <= (w_s == 13'd0) || (h_s == 13'd0);
      r8_q[1]   <= r8_c;
      cx1_q     <= {w_s - 13'd1, 7'd0};
      cy1_q     <= {h_s - 13'd1, 7'd0};
      // stage 2
      ax2_q     <= ax_d;
      ay2_q     <= ay_d;
      hx2_q     <= cx1_q - r8_q[1];
      hy2_q     <= cy1_q - r8_q[1];
      r2_q[2]   <= 40'(r8_q[1] * r8_q[1]);
      hi2_q[2]  <= 42'(hi_c * hi_c);
      lo2_q[2]  <= (int'(r8_q[1]) > int'(rrac_pkg::BAND_Q8)) ? 40'(lo_c * lo_c) : 40'd0;
      // stage 3
      qx3_q     <= qx_d;
      qy3_q     <= qy_d;
      r2_q[3]   <= r2_q[2];
      hi2_q[3]  <= hi2_q[2];
      lo2_q[3]  <= lo2_q[2];
      // stage 4
      ox2_q     <= ox2_d;
      oy2_q     <= oy2_d;
      qx4_q     <= qx3_q;
      qy4_q     <= qy3_q;
      r2_q[4]   <= r2_q[3];
      hi2_q[4]  <= hi2_q[3];
      lo2_q[4]  <= lo2_q[3];
      // stage 5
      hits_q    <= hits_d;
      for (int i = 2; i <= 4; i++) begin
        s_q[i]    <= s_q[i-1];
        fill_q[i] <= fill_q[i-1];
        zero_q[i] <= zero_q[i-1];
        r8_q[i]   <= r8_q[i-1];
      end
    end
  end

  assign valid_o = v_q[4];
  assign hits_o  = hits_q;

endmodule

[design/rrac_blend.sv]
// Blend pipeline: hit count, coverage weights, products and a four-stage rounding divider.
`timescale 1ns / 1ps

module rrac_blend #(
  parameter int MAX_SAMPLES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [MAX_SAMPLES*MAX_SAMPLES-1:0] hits_i,
  input  rrac_pkg::cfg_t                     cfg_i,
  output logic                               valid_o,
  output rrac_pkg::pix_out_t                 pix_o
);

  localparam int NS = MAX_SAMPLES;
  localparam int CW = $clog2(NS + 1);
  localparam int TW = $clog2(NS * NS + 1);
  localparam int RW = 25;

  logic [8:0]  v_q;
  logic [CW-1:0] row_q [NS];
  logic [TW-1:0] tot_q;
  logic [15:0] n_q, d3_q;
  logic [23:0] acc_q [3];
  logic [15:0] d4_q;
  logic [RW-1:0] rem_q [5][3];
  logic [16:0]   den_q [5];
  logic [7:0]    quo_q [5][3];

  logic [CW-1:0] row_d [NS];
  logic [TW-1:0] tot_d;
  logic [3:0]    s_c;
  logic [6:0]    ss;
  logic [7:0]    fgc [3], bgc [3];

  always_comb begin
    for (int r = 0; r < NS; r++) begin
      row_d[r] = '0;
      for (int c = 0; c < NS; c++) begin
        row_d[r] = row_d[r] + CW'(hits_i[r*NS+c]);
      end
    end
    tot_d = '0;
    for (int r = 0; r < NS; r++) begin
      tot_d = tot_d + TW'(row_q[r]);
    end
    if (cfg_i.samples_per_axis == 4'd0) begin
      s_c = 4'd1;
    end else if (int'(cfg_i.samples_per_axis) > NS) begin
      s_c = 4'(NS);
    end else begin
      s_c = cfg_i.samples_per_axis;
    end
    ss     = 7'(s_c * s_c);
    fgc[0] = cfg_i.fg_color[31:24];
    fgc[1] = cfg_i.fg_color[23:16];
    fgc[2] = cfg_i.fg_color[15:8];
    bgc[0] = cfg_i.bg_color[23:16];
    bgc[1] = cfg_i.bg_color[15:8];
    bgc[2] = cfg_i.bg_color[7:0];
  end

  // Restoring divider, two quotient bits per stage.
  logic [RW-1:0] rem_d [4][3];
  logic [7:0]    quo_d [4][3];

  always_comb begin
    logic [RW-1:0] rem, trial;
    logic [7:0]    quo;
    for (int j = 0; j < 4; j++) begin
      for (int c = 0; c < 3; c++) begin
        rem = rem_q[j][c];
        quo = quo_q[j][c];
        for (int b = 0; b < 2; b++) begin
          trial = RW'(den_q[j]) << (7 - 2*j - b);
          if (rem >= trial) begin
            rem = rem - trial;
            quo[7 - 2*j - b] = 1'b1;
          end
        end
        rem_d[j][c] = rem;
        quo_d[j][c] = quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
      tot_q <= tot_d;
      n_q   <= 16'(tot_q * cfg_i.fg_color[7:0]);
      d3_q  <= 16'({ss, 8'd0} - {8'd0, ss});
      d4_q  <= d3_q;
      for (int c = 0; c < 3; c++) begin
        acc_q[c]    <= 24'(fgc[c] * n_q) + 24'(bgc[c] * (d3_q - n_q));
        rem_q[0][c] <= RW'({acc_q[c], 1'b0}) + RW'(d4_q);
        quo_q[0][c] <= 8'd0;
      end
      den_q[0] <= {d4_q, 1'b0};
      for (int j = 0; j < 4; j++) begin
        rem_q[j+1] <= rem_d[j];
        quo_q[j+1] <= quo_d[j];
        den_q[j+1] <= den_q[j];
      end
    end
  end

  assign valid_o         = v_q[8];
  assign pix_o.out_red   = quo_q[4][0];
  assign pix_o.out_green = quo_q[4][1];
  assign pix_o.out_blue  = quo_q[4][2];

endmodule

[design/rounded_rect_aa_coverage_core.sv]
// Top level of the supersampled rounded-rectangle coverage core.
//
// Input channel: in_valid_i / in_stall_o carry one pixel word (column, row)
// inside the rectangle. Output channel: out_valid_o / out_stall_i carry the
// blended RGB word for that pixel. A word moves at a clock edge with valid
// high and stall low.
// One pixel is taken every cycle while no result waits under out_stall_i.
// Five stages evaluate all sample points of the pixel in parallel lanes,
// nine more count hits, weight the colours and run a two-bits-per-stage
// rounding divider.
// The pipeline advances as a whole: when a result waits under out_stall_i the
// stages hold and in_stall_o rises in the same cycle, so no word is lost or
// repeated. Bubbles travel with their valid bits.
// Reset clears all valid bits and loads the register defaults: 64 by 64,
// radius 8, fill, 4 by 4 samples, white foreground, black background.
// Write configuration over the APB port only while the pipeline is empty.
`timescale 1ns / 1ps

module rounded_rect_aa_coverage_core #(
  parameter int MAX_DIM     = 4096,
  parameter int MAX_SAMPLES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rrac_pkg::pix_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rrac_pkg::pix_out_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rrac_pkg::cfg_t                   cfg;
  logic                             en;
  logic                             geom_valid;
  logic [MAX_SAMPLES*MAX_SAMPLES-1:0] hits;

  // advance unless a finished word is held back
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  rrac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrac_geom #(
    .MAX_DIM     (MAX_DIM),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_data_i),
    .cfg_i   (cfg),
    .valid_o (geom_valid),
    .hits_o  (hits)
  );

  rrac_blend #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geom_valid),
    .hits_i  (hits),
    .cfg_i   (cfg),
    .valid_o (out_valid_o),
    .pix_o   (out_data_o)
  );

endmodule
